// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on clk with synchronous reset rst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define SRW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define SRW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SRW_ASSERT(label, prop, msg)
`define SRW_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/sysrw_pkg.sv =====
// ----------------------------------------------------------------------------
// sysrw_pkg
// Word types, register addresses and masks of the system register decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sysrw_pkg;

  // Input word: one bus write
  typedef struct packed {
    logic [15:0] bus_address;
    logic [15:0] write_data;
    logic        byte_access;
  } in_word_t;

  // Result word: register file after the write
  typedef struct packed {
    logic        handled;
    logic [15:0] kbd_status_value;
    logic [15:0] kbd_ctrl_value;
    logic [15:0] scroll_value;
    logic [15:0] port_out_value;
    logic [15:0] port_in_value;
    logic [15:0] mem_map_value;
    logic [15:0] tape_sound_value;
    logic        stop_blocked;
    logic [2:0]  screen_page;
    logic        write_seen;
    logic [1:0]  synth_access;
  } out_word_t;

  // Configuration register indexes
  localparam logic CFG_LOOPBACK = 1'b0;
  localparam logic CFG_SYNTH    = 1'b1;

  // Synthesizer access codes
  localparam logic [1:0] SYNTH_NONE = 2'd0;
  localparam logic [1:0] SYNTH_ADDR = 2'd1;
  localparam logic [1:0] SYNTH_DATA = 2'd2;

  // Register addresses (bit 0 ignored)
  localparam logic [15:0] ADDR_MATCH_MASK = 16'o177776;
  localparam logic [15:0] ADDR_KBD_STATUS = 16'o177660;
  localparam logic [15:0] ADDR_KBD_CTRL   = 16'o177662;
  localparam logic [15:0] ADDR_SCROLL     = 16'o177664;
  localparam logic [15:0] ADDR_PORT       = 16'o177714;
  localparam logic [15:0] ADDR_SYSTEM     = 16'o177716;

  // Write masks
  localparam logic [15:0] MASK_KBD_STATUS = 16'o000100;
  localparam logic [15:0] MASK_KBD_CTRL   = 16'o147400;
  localparam logic [15:0] MASK_SCROLL     = 16'o001377;
  localparam logic [15:0] MASK_MEM_MAP    = 16'o077437;
  localparam logic [15:0] MASK_TAPE_SOUND = 16'o000340;
  localparam logic [15:0] SYS_UPDATE_BIT  = 16'o004000;

  // Reset values
  localparam logic [15:0] RST_KBD_STATUS = 16'o000200;
  localparam logic [15:0] RST_SCROLL     = 16'o000330;
  localparam logic [15:0] RST_TAPE_SOUND = 16'o000200;

  // Screen page codes
  localparam logic [2:0] PAGE_NORMAL = 3'd5;
  localparam logic [2:0] PAGE_ALT    = 3'd6;

  // Byte writes use the low data byte; an odd address moves it high
  function automatic logic [15:0] lane_data(input logic [15:0] addr,
                                            input logic [15:0] data,
                                            input logic        is_byte);
    logic [15:0] v;
    v = data;
    if (is_byte) begin
      v = addr[0] ? {data[7:0], 8'h00} : {8'h00, data[7:0]};
    end
    return v;
  endfunction

  function automatic logic [15:0] merge(input logic [15:0] old_val,
                                        input logic [15:0] new_val,
                                        input logic [15:0] mask);
    return (old_val & ~mask) | (new_val & mask);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/system_register_write_decoder.sv =====
// ----------------------------------------------------------------------------
// system_register_write_decoder
// Applies bus writes to five memory-mapped system registers and reports
// the register file after each write.
// ----------------------------------------------------------------------------
// Each accepted bus write yields one result word. The write is captured
// in an input register, then decoded and merged into the register file,
// and the result is held in an output register, loaded with the file
// update. One write is accepted every cycle while results are taken; the
// input register lets one more write in while a result is stalled. The
// register-file update path (address compare and mask merge) sets the rate.
// Configuration (loopback, synthesizer present) is written through cfg_we.
`default_nettype none

`include "assert_macros.svh"

module system_register_write_decoder (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input channel
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire sysrw_pkg::in_word_t  in_word,
  // result channel
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output      sysrw_pkg::out_word_t out_word,
  // configuration port
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic                 cfg_data
);

  import sysrw_pkg::*;

  // Handshake and pipeline registers
  logic      in_valid_r;
  in_word_t  in_word_r;
  logic      out_valid_r;
  out_word_t out_word_r;
  logic      advance;
  logic      in_take;

  // Configuration
  logic loopback_r;
  logic synth_r;

  // Register file
  logic [15:0] kbd_status_r, kbd_status_nxt;
  logic [15:0] kbd_ctrl_r,   kbd_ctrl_nxt;
  logic [15:0] scroll_r,     scroll_nxt;
  logic [15:0] port_out_r,   port_out_nxt;
  logic [15:0] port_in_r,    port_in_nxt;
  logic [15:0] mem_map_r,    mem_map_nxt;
  logic [15:0] tape_sound_r, tape_sound_nxt;
  logic        sys_flag_r,   sys_flag_nxt;
  logic        hit;
  logic [1:0]  synth_nxt;
  logic [15:0] lane;
  logic [15:0] kbd_v;
  out_word_t   result;

  // Stage 2 moves unless its result is still stalled
  assign advance  = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loopback_r <= 1'b0;
      synth_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LOOPBACK: loopback_r <= cfg_data;
        CFG_SYNTH:    synth_r    <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_word;
    end
  end

  // Decode and merge
  always_comb begin
    lane           = lane_data(in_word_r.bus_address, in_word_r.write_data,
                               in_word_r.byte_access);
    kbd_v          = in_word_r.write_data;
    kbd_status_nxt = kbd_status_r;
    kbd_ctrl_nxt   = kbd_ctrl_r;
    scroll_nxt     = scroll_r;
    port_out_nxt   = port_out_r;
    port_in_nxt    = port_in_r;
    mem_map_nxt    = mem_map_r;
    tape_sound_nxt = tape_sound_r;
    sys_flag_nxt   = sys_flag_r;
    synth_nxt      = SYNTH_NONE;
    hit            = 1'b1;

    unique case (in_word_r.bus_address & ADDR_MATCH_MASK)
      ADDR_KBD_STATUS: begin
        // byte write merges with the old value in the other lane
        if (in_word_r.byte_access) begin
          kbd_v = in_word_r.bus_address[0]
                ? {in_word_r.write_data[7:0], kbd_status_r[7:0]}
                : {kbd_status_r[15:8], in_word_r.write_data[7:0]};
        end
        kbd_status_nxt = merge(kbd_status_r, kbd_v, MASK_KBD_STATUS);
      end
      ADDR_KBD_CTRL: begin
        kbd_ctrl_nxt = merge(kbd_ctrl_r, lane, MASK_KBD_CTRL);
      end
      ADDR_SCROLL: begin
        // always a word write: a byte write has a zero high byte
        scroll_nxt = merge(scroll_r,
                           in_word_r.byte_access
                             ? {8'h00, in_word_r.write_data[7:0]}
                             : in_word_r.write_data,
                           MASK_SCROLL);
      end
      ADDR_PORT: begin
        if (synth_r) begin
          synth_nxt = in_word_r.byte_access ? SYNTH_DATA : SYNTH_ADDR;
        end
        port_out_nxt = lane;
        if (loopback_r) begin
          port_in_nxt = lane;
        end
      end
      ADDR_SYSTEM: begin
        if ((lane & SYS_UPDATE_BIT) != 16'h0000) begin
          mem_map_nxt    = merge(mem_map_r, lane, MASK_MEM_MAP);
          tape_sound_nxt = merge(tape_sound_r, lane, MASK_TAPE_SOUND);
        end
        sys_flag_nxt = 1'b1;
      end
      default: begin
        hit = 1'b0;
      end
    endcase

    result.handled          = hit;
    result.kbd_status_value = kbd_status_nxt;
    result.kbd_ctrl_value   = kbd_ctrl_nxt;
    result.scroll_value     = scroll_nxt;
    result.port_out_value   = port_out_nxt;
    result.port_in_value    = port_in_nxt;
    result.mem_map_value    = mem_map_nxt;
    result.tape_sound_value = tape_sound_nxt;
    result.stop_blocked     = kbd_ctrl_nxt[15];
    result.screen_page      = mem_map_nxt[2] ? PAGE_ALT : PAGE_NORMAL;
    result.write_seen       = sys_flag_nxt;
    result.synth_access     = synth_nxt;
  end

  // Register file update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbd_status_r <= RST_KBD_STATUS;
      kbd_ctrl_r   <= 16'h0000;
      scroll_r     <= RST_SCROLL;
      port_out_r   <= 16'h0000;
      port_in_r    <= 16'h0000;
      mem_map_r    <= 16'h0000;
      tape_sound_r <= RST_TAPE_SOUND;
      sys_flag_r   <= 1'b0;
    end else if (advance) begin
      kbd_status_r <= kbd_status_nxt;
      kbd_ctrl_r   <= kbd_ctrl_nxt;
      scroll_r     <= scroll_nxt;
      port_out_r   <= port_out_nxt;
      port_in_r    <= port_in_nxt;
      mem_map_r    <= mem_map_nxt;
      tape_sound_r <= tape_sound_nxt;
      sys_flag_r   <= sys_flag_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= result;
    end
  end

  // Checks
  `SRW_ASSERT(a_stall_only_full, !in_stall || in_valid_r, "input stall with empty input register")
  `SRW_ASSERT_NEXT(a_flag_sticky, sys_flag_r, sys_flag_r, "write-seen flag cleared")
  `SRW_ASSERT_NEXT(a_miss_no_change, advance && !hit, $stable(kbd_status_r) && $stable(kbd_ctrl_r) && $stable(scroll_r) && $stable(port_out_r) && $stable(port_in_r) && $stable(mem_map_r) && $stable(tape_sound_r), "unmatched write changed state")
  `SRW_ASSERT(a_synth_needs_hit, !out_valid_r || out_word_r.synth_access == SYNTH_NONE || out_word_r.handled, "synth access on unmatched write")
  `SRW_ASSERT(a_page_code, !out_valid_r || out_word_r.screen_page == PAGE_NORMAL || out_word_r.screen_page == PAGE_ALT, "bad screen page")

endmodule

`default_nettype wire
